// ----- rtl/mmvm_pkg.sv -----
// Package for the modular matrix-vector multiply block.
// Holds field widths, operation and register codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package mmvm_pkg;

  localparam int VAL_W     = 32;   // field element width
  localparam int IDX_W     = 4;    // row / col index width
  localparam int DIM_W     = 5;    // dimension register width
  localparam int OP_W      = 2;    // operation field width
  localparam int PROD_W    = 2 * VAL_W;
  localparam int RCNT_W    = 7;    // reducer step counter, holds PROD_W
  localparam int CFG_IDX_W = 2;

  // steps of the bit-serial remainder unit
  localparam logic [RCNT_W-1:0] RED_LD_STEPS  = RCNT_W'(VAL_W);
  localparam logic [RCNT_W-1:0] RED_MUL_STEPS = RCNT_W'(PROD_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM   = 2'd1;

  localparam logic [VAL_W-1:0] PRIME_RST = 32'hFFFF_FFFB;
  localparam logic [DIM_W-1:0] DIM_RST   = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_LD_MAT  = 2'd0,
    OP_LD_VEC  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic             ld_start;   // latch value and address, start 32-step reduction
    logic             wr_mat;     // write reduced value to matrix store
    logic             wr_vec;     // write reduced value to vector store
    logic             mul_start;  // multiply read operands, start 64-step reduction
    logic             acc_clr;
    logic             acc_en;     // add remainder into accumulator mod p
    logic             emit;       // load output register from accumulator
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
    logic             last;
  } mmvm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic red_done;
    logic out_free;
  } mmvm_sts_t;

endpackage

`default_nettype wire

// ----- rtl/modular_matrix_vector_multiply.sv -----
// Modular matrix-vector multiply, top level. Uses mmvm_pkg, mmvm_ctrl, mmvm_dp.
// Load transfer: accept, 32-step bit-serial remainder, write; the next one waits for the write.
// Compute transfer: per matrix term read, multiply, 64-step remainder and accumulate,
//   and per row an emit; the next accept waits for the last row's emit, which waits
//   further while the output stalls; one remainder unit sets this.
// Reset (synchronous, rst_n low): control idle, modulus 4294967291, dimension 16;
//   stores are not cleared.
`default_nettype none

module modular_matrix_vector_multiply
  import mmvm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [IDX_W-1:0]     in_row,
  input  wire logic [IDX_W-1:0]     in_col,
  input  wire logic [VAL_W-1:0]     in_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [IDX_W-1:0]          out_row_index,
  output logic [VAL_W-1:0]          out_product_value,
  output logic                      out_last
);

  logic [VAL_W-1:0] prime_modulus_r;
  logic [DIM_W-1:0] dimension_r;
  mmvm_cmd_t        cmd;
  mmvm_sts_t        sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_modulus_r <= PRIME_RST;
      dimension_r     <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIME: prime_modulus_r <= cfg_wdata;
        CFG_DIM:   dimension_r     <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  mmvm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .dimension    (dimension_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .sts          (sts),
    .cmd          (cmd)
  );

  mmvm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .prime_modulus     (prime_modulus_r),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

  // a row result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("row result emitted into occupied output register");

  // only one datapath operation started per cycle
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_start, cmd.mul_start, cmd.emit}))
    else $error("conflicting datapath commands");

  // a compute transfer with rows to produce holds off the input channel
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_COMPUTE && dimension_r != '0)
    |=> !in_ready)
    else $error("input accepted during compute");

  // stores are written only when a reduction has finished
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_mat || cmd.wr_vec) |-> (sts.red_done && !in_ready))
    else $error("store written before reduction finished");

endmodule

`default_nettype wire

// ----- rtl/mmvm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mmvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/mmvm_dp.sv -----
// Datapath: matrix and vector stores, multiplier, bit-serial remainder unit,
// modular accumulator and output register. Uses mmvm_pkg and mmvm_ram.
`default_nettype none

module mmvm_dp
  import mmvm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VAL_W-1:0] prime_modulus,
  input  wire logic [IDX_W-1:0] in_row,
  input  wire logic [IDX_W-1:0] in_col,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire mmvm_cmd_t        cmd,
  output mmvm_sts_t             sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [IDX_W-1:0]      out_row_index,
  output logic [VAL_W-1:0]      out_product_value,
  output logic                  out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int VW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [IDX_W-1:0]  row_r, col_r;
  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [RCNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;

  logic [VAL_W:0]    mod_ext;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    acc_sum;
  logic [VAL_W-1:0]  mat_rdata, vec_rdata;
  logic [AW-1:0]     mat_waddr, mat_raddr;
  logic [VW-1:0]     vec_waddr, vec_raddr;

  // modulus zero stands for 2^32
  assign mod_ext = (prime_modulus == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, prime_modulus};

  // store addressing
  assign mat_waddr = AW'(int'(row_r) * MAX_DIM + int'(col_r));
  assign mat_raddr = AW'(int'(cmd.row_idx) * MAX_DIM + int'(cmd.col_idx));
  assign vec_waddr = VW'(row_r);
  assign vec_raddr = VW'(cmd.col_idx);

  mmvm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (cmd.wr_mat),
    .waddr (mat_waddr),
    .wdata (rem_r),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mmvm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec_ram (
    .clk   (clk),
    .we    (cmd.wr_vec),
    .waddr (vec_waddr),
    .wdata (rem_r),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // restoring remainder: one dividend bit per cycle, MSB first
  always_comb begin
    trial   = {rem_r, dvd_r[PROD_W-1]};
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.ld_start) begin
      dvd_nxt = {in_value, {VAL_W{1'b0}}};
      rem_nxt = '0;
      cnt_nxt = RED_LD_STEPS;
    end else if (cmd.mul_start) begin
      dvd_nxt = mat_rdata * vec_rdata;
      rem_nxt = '0;
      cnt_nxt = RED_MUL_STEPS;
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
      rem_nxt = (trial >= mod_ext) ? VAL_W'(trial - mod_ext) : trial[VAL_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // accumulator: both terms below the modulus, one subtract at most
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, rem_r};
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.acc_en) begin
      acc_nxt = (acc_sum >= mod_ext) ? VAL_W'(acc_sum - mod_ext) : acc_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    if (cmd.ld_start) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.emit) begin
      out_idx_r  <= cmd.row_idx;
      out_val_r  <= acc_r;
      out_last_r <= cmd.last;
    end
  end

  assign sts.red_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_row_index     = out_idx_r;
  assign out_product_value = out_val_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/mmvm_ctrl.sv -----
// Controller: sequences loads and the row/column walk of a compute transfer.
// Uses mmvm_pkg; drives the datapath through mmvm_cmd_t.
`default_nettype none

module mmvm_ctrl
  import mmvm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [DIM_W-1:0] dimension,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [IDX_W-1:0] in_row,
  input  wire logic [IDX_W-1:0] in_col,
  input  wire mmvm_sts_t        sts,
  output mmvm_cmd_t             cmd
);

  localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LRED,   // reducing a loaded value
    S_RD,     // store read in flight
    S_MUL,    // multiply operands
    S_CRED,   // reducing a product
    S_EMIT    // hand row result to output register
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             tgt_vec_r, tgt_vec_nxt;
  logic [DIM_W-1:0] n_eff;
  logic [DIM_W-1:0] n_last;
  logic             mat_ok, vec_ok;

  // dimension saturated to what the stores and result count allow
  assign n_eff  = (dimension > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : dimension;
  assign n_last = n_eff - 1'b1;
  assign mat_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign vec_ok = (int'(in_row) < MAX_DIM);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    tgt_vec_nxt = tgt_vec_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.row_idx = i_r;
    cmd.col_idx = j_r;
    cmd.last    = ({1'b0, i_r} == n_last);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op_t'(in_operation))
            OP_LD_MAT: begin
              if (mat_ok) begin
                cmd.ld_start = 1'b1;
                tgt_vec_nxt  = 1'b0;
                state_nxt    = S_LRED;
              end
            end
            OP_LD_VEC: begin
              if (vec_ok) begin
                cmd.ld_start = 1'b1;
                tgt_vec_nxt  = 1'b1;
                state_nxt    = S_LRED;
              end
            end
            OP_COMPUTE: begin
              if (n_eff != '0) begin
                cmd.acc_clr = 1'b1;
                i_nxt       = '0;
                j_nxt       = '0;
                state_nxt   = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LRED: begin
        if (sts.red_done) begin
          cmd.wr_mat = !tgt_vec_r;
          cmd.wr_vec = tgt_vec_r;
          state_nxt  = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_CRED;
      end
      S_CRED: begin
        if (sts.red_done) begin
          cmd.acc_en = 1'b1;
          if ({1'b0, j_r} == n_last) begin
            state_nxt = S_EMIT;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.acc_clr = 1'b1;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and sequencing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      tgt_vec_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      tgt_vec_r <= tgt_vec_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- bench/mmvm_checker.sv -----
// Scoreboard for modular_matrix_vector_multiply: watches the config port and both channels,
// predicts every product row and compares each output transfer with the oldest expectation.
// Depends on mmvm_pkg for widths, operation codes and register indexes.

module mmvm_checker
  import mmvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IDX_W-1:0]     in_row,
  input  logic [IDX_W-1:0]     in_col,
  input  logic [VAL_W-1:0]     in_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [IDX_W-1:0]     out_row_index,
  input  logic [VAL_W-1:0]     out_product_value,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   rows_pending,
  output int                   rows_checked
);

  localparam int MAX_ROWS = 16;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [VAL_W-1:0] value;
    logic             last;
  } row_result_t;

  row_result_t      expected_rows[$];
  logic [VAL_W-1:0] modulus;
  logic [DIM_W-1:0] dim_reg;
  logic [VAL_W-1:0] entry_store[MAX_ROWS][MAX_ROWS];
  logic [VAL_W-1:0] elem_store[MAX_ROWS];
  int               mismatches = 0;
  int               checked = 0;

  // modulus zero stands for 2^32
  function automatic logic [63:0] field_size();
    return (modulus == '0) ? 64'h1_0000_0000 : {32'b0, modulus};
  endfunction

  function automatic logic [VAL_W-1:0] reduce_value(logic [VAL_W-1:0] v);
    return VAL_W'({32'b0, v} % field_size());
  endfunction

  // one row per dimension in use, terms reduced in full before accumulation
  task automatic predict_product_rows();
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] term;
    int          n;
    row_result_t r;
    m = field_size();
    n = (dim_reg > MAX_ROWS) ? MAX_ROWS : int'(dim_reg);
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < n; j++) begin
        term = ({32'b0, entry_store[i][j]} * {32'b0, elem_store[j]}) % m;
        acc = (acc + term) % m;
      end
      r.row   = IDX_W'(i);
      r.value = VAL_W'(acc);
      r.last  = (i == n - 1);
      expected_rows.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    row_result_t exp_row;
    if (!rst_n) begin
      modulus = PRIME_RST;
      dim_reg = DIM_RST;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_PRIME) modulus = cfg_wdata;
        else if (cfg_index == CFG_DIM) dim_reg = cfg_wdata[DIM_W-1:0];
      end

      // input transfer
      if (in_valid && in_ready) begin
        case (in_operation)
          OP_LD_MAT:  entry_store[in_row][in_col] = reduce_value(in_value);
          OP_LD_VEC:  elem_store[in_row] = reduce_value(in_value);
          OP_COMPUTE: predict_product_rows();
          default: ;  // unused code, ignored
        endcase
      end

      // output transfer against oldest expectation
      if (out_valid && out_ready) begin
        checked++;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected row result: row %0d value %0d last %0b",
                     out_row_index, out_product_value, out_last);
        end else begin
          exp_row = expected_rows.pop_front();
          if (exp_row.row != out_row_index || exp_row.value != out_product_value ||
              exp_row.last != out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected row %0d value %0d last %0b, got %0d %0d %0b",
                       exp_row.row, exp_row.value, exp_row.last,
                       out_row_index, out_product_value, out_last);
          end
        end
      end
    end
    rows_pending <= expected_rows.size();
    fail_count   <= mismatches;
    rows_checked <= checked;
  end

endmodule

// ----- bench/tb.sv -----
// Top of the modular_matrix_vector_multiply bench: clock, reset, config writes and stimulus
// with random idling on both channels; the verdict comes from mmvm_checker.
// Depends on mmvm_pkg, mmvm_checker and the block itself.

module tb;
  import mmvm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
  localparam int              TOTAL_ITEMS     = 460;
  localparam int              FULL_SIZE_ITEMS = 180;  // filling the 16x16 square at the end
  localparam int              NUM_PHASES      = 9;
  localparam int              SETTLE          = 100;  // covers a load in flight with margin

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [IDX_W-1:0]     in_row = '0;
  logic [IDX_W-1:0]     in_col = '0;
  logic [VAL_W-1:0]     in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     out_row_index;
  logic [VAL_W-1:0]     out_product_value;
  logic                 out_last;

  int fail_count;
  int rows_pending;
  int rows_checked;

  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;
  int products_sent = 0;
  int cur_dim = 16;
  logic [VAL_W-1:0] cur_prime = PRIME_RST;
  bit mat_written[16][16];
  bit vec_written[16];

  logic [VAL_W-1:0] phase_prime[NUM_PHASES] = '{32'd65521, 32'd4294967291, 32'd0,
                                                32'd13, 32'd2147483647, 32'd1000000,
                                                32'd4294967295, 32'd2, 32'd97};
  int phase_dim[NUM_PHASES] = '{3, 5, 2, 6, 4, 1, 8, 3, 5};

  modular_matrix_vector_multiply i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

  mmvm_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_product_value (out_product_value),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .rows_pending      (rows_pending),
    .rows_checked      (rows_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // value mix: extremes, values around the modulus, small and random words
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return cur_prime - VAL_W'($urandom_range(1));
      3:       return cur_prime + 1;
      4:       return VAL_W'($urandom_range(15));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one transfer on the input channel; valid stays high if the next one follows at once
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [VAL_W-1:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_row       <= r;
    in_col       <= c;
    in_value     <= v;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LD_MAT) mat_written[r][c] = 1'b1;
    else if (op == OP_LD_VEC) vec_written[r] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_COMPUTE) products_sent++;
  endtask

  // hold the sender until every expected row has arrived
  task automatic wait_for_rows();
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
  endtask

  task automatic set_config(logic [VAL_W-1:0] p, int d);
    wait_for_rows();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRIME;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= CFG_DIM;
    cfg_wdata <= VAL_W'(d);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_prime = p;
    cur_dim   = (d > 16) ? 16 : d;
  endtask

  task automatic send_compute();
    send_item(OP_COMPUTE, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
              VAL_W'($urandom));
  endtask

  // never-written entries inside the active square get loaded before a compute
  task automatic fill_missing(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!mat_written[r][c]) send_item(OP_LD_MAT, IDX_W'(r), IDX_W'(c), pick_value());
    for (int r = 0; r < n; r++)
      if (!vec_written[r])
        send_item(OP_LD_VEC, IDX_W'(r), IDX_W'($urandom_range(15)), pick_value());
  endtask

  task automatic random_load(int n, bit anywhere);
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    r = (anywhere || n == 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom_range(n - 1));
    c = (anywhere || n == 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom_range(n - 1));
    if ($urandom_range(1)) send_item(OP_LD_MAT, r, c, pick_value());
    else send_item(OP_LD_VEC, r, IDX_W'($urandom_range(15)), pick_value());
  endtask

  // mostly loads then a product; some noise and some loads left without a product
  task automatic run_sequence();
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_item(OP_UNUSED, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                VAL_W'($urandom));
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 4)) random_load(cur_dim, 1'b1);
    end else begin
      repeat ($urandom_range(cur_dim * cur_dim + cur_dim))
        random_load(cur_dim, $urandom_range(9) == 0);
      fill_missing(cur_dim);
      send_compute();
      if ($urandom_range(9) == 0) wait_for_rows();
    end
  endtask

  initial begin
    int goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: value extremes at the reset modulus, corner indices, unused code
    set_config(PRIME_RST, 2);
    send_item(OP_LD_MAT, 4'd0, 4'd0, '1);
    send_item(OP_LD_MAT, 4'd0, 4'd1, PRIME_RST);
    send_item(OP_LD_MAT, 4'd1, 4'd0, '0);
    send_item(OP_LD_MAT, 4'd1, 4'd1, PRIME_RST - 1);
    send_item(OP_LD_VEC, 4'd0, 4'd15, '1);
    send_item(OP_LD_VEC, 4'd1, 4'd0, PRIME_RST - 1);
    send_item(OP_LD_MAT, 4'd15, 4'd15, 32'h5A5A_5A5A);
    send_item(OP_LD_VEC, 4'd15, 4'd15, 32'hA5A5_A5A5);
    send_item(OP_UNUSED, 4'd15, 4'd15, '1);
    send_compute();
    // modulus zero wraps at 2^32; older entries stay from the previous modulus
    set_config('0, 2);
    send_item(OP_LD_MAT, 4'd0, 4'd0, '1);
    send_item(OP_LD_VEC, 4'd0, 4'd0, '1);
    send_compute();
    // modulus one gives all zeros
    set_config(32'd1, 3);
    fill_missing(3);
    send_compute();
    set_config(32'd2, 1);
    send_compute();
    // dimension zero: no rows
    set_config(PRIME_RST, 0);
    send_compute();
    send_item(OP_LD_VEC, 4'd3, 4'd0, '1);

    // random phases share what the item total leaves after the full-size part;
    // idling mode changes every third phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 3)
        0:       begin send_idle = 34; recv_idle = 84; end
        1:       begin send_idle = 84; recv_idle = 34; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      set_config(phase_prime[ph], phase_dim[ph]);
      goal = items_sent + (TOTAL_ITEMS - FULL_SIZE_ITEMS - items_sent) / (NUM_PHASES - ph);
      do run_sequence(); while (items_sent < goal);
    end

    // full size: dimension above the store saturates, then exactly sixteen
    set_config(PRIME_RST, 31);
    fill_missing(16);
    repeat (8) random_load(16, 1'b1);
    send_compute();
    set_config(32'hFFFF_FFF1, 16);
    send_compute();

    wait_for_rows();
    repeat (200) @(posedge clk);
    $display("%0d items transferred, %0d products, %0d rows checked",
             items_sent, products_sent, rows_checked);
    $display("moduli 0, 1, 2, primes and non-primes; dimensions 0 to 6, 8, 16, saturated 31");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("timeout with %0d rows still expected", rows_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
